@@ src/ascii_safe_escape_encoder_assert.svh @@
// Assertion macros for the checker file of the escape encoder.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef ASCII_SAFE_ESCAPE_ENCODER_ASSERT_SVH
`define ASCII_SAFE_ESCAPE_ENCODER_ASSERT_SVH

// Checked only outside reset.
`define ASE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("escape encoder assertion failed");

// Checked at every edge, reset included.
`define ASE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("escape encoder reset assertion failed");

`endif

@@ src/ase_pkg.sv @@
// Shared types and constants of the ASCII-safe escape encoder.
// Depends on nothing; used by every module of the block.
package ase_pkg;

  localparam int CODE_W      = 8;
  localparam int CHAR_W      = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int IDX_W       = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam code_t LOW_LIMIT  = 8'd32;
  localparam code_t HIGH_LIMIT = 8'd127;
  localparam code_t PCT_CODE   = 8'd37;
  localparam char_t PCT_CHAR   = 7'd37;
  localparam char_t DIGIT_ZERO = 7'd48;

  // One emitted character and its end-of-run mark.
  typedef struct packed {
    char_t ch;
    logic  last;
  } ase_sym_t;

endpackage

@@ src/ase_run_sel.sv @@
// Expands one character code into its escaped run and picks one position of it.
// Depends on ase_pkg.
module ase_run_sel (
  input  ase_pkg::code_t   code,
  input  ase_pkg::idx_t    idx,
  output ase_pkg::ase_sym_t sym
);
  import ase_pkg::*;

  logic        esc;
  logic        pct;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens10;
  logic [6:0]  ones_w;
  logic [3:0]  ones;
  logic [1:0]  nd;
  char_t       run [5];
  idx_t        len;

  assign esc = (code < LOW_LIMIT) || (code > HIGH_LIMIT);
  assign pct = (code == PCT_CODE);

  // Hundreds by compare, tens by a reciprocal multiply valid below 1029.
  always_comb begin
    if (code >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(code - 8'd200);
    end else if (code >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(code - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = code[6:0];
    end
  end

  assign prod   = {8'b0, rem} * 15'd205;
  assign tens   = prod[14:11];
  assign tens10 = 7'(tens) * 7'd10;
  assign ones_w = rem - tens10;
  assign ones   = ones_w[3:0];
  assign nd     = (code >= 8'd100) ? 2'd3 : (code >= 8'd10) ? 2'd2 : 2'd1;

  always_comb begin
    run[0] = PCT_CHAR;
    run[1] = PCT_CHAR;
    run[2] = PCT_CHAR;
    run[3] = PCT_CHAR;
    run[4] = PCT_CHAR;
    len    = 3'd1;
    if (esc) begin
      len = 3'(nd) + 3'd2;
      case (nd)
        2'd3: begin
          run[1] = DIGIT_ZERO + 7'(hund);
          run[2] = DIGIT_ZERO + 7'(tens);
          run[3] = DIGIT_ZERO + 7'(ones);
        end
        2'd2: begin
          run[1] = DIGIT_ZERO + 7'(tens);
          run[2] = DIGIT_ZERO + 7'(ones);
        end
        default: begin
          run[1] = DIGIT_ZERO + 7'(ones);
        end
      endcase
    end else if (pct) begin
      len = 3'd2;
    end else begin
      run[0] = code[6:0];
    end
  end

  always_comb begin
    case (idx)
      3'd0:    sym.ch = run[0];
      3'd1:    sym.ch = run[1];
      3'd2:    sym.ch = run[2];
      3'd3:    sym.ch = run[3];
      3'd4:    sym.ch = run[4];
      default: sym.ch = PCT_CHAR;
    endcase
    sym.last = (idx == (len - 3'd1));
  end

endmodule

@@ src/ascii_safe_escape_encoder.sv @@
// Top level of the ASCII-safe escape encoder: input register, run expansion, output register.
// Depends on ase_pkg and ase_run_sel.
//
// Usage:
//   The in_ channel carries one character code per transaction in in_tdata.
//   The out_ channel carries one 7-bit ASCII character per transaction in
//   out_tdata, with out_tlast high on the final character of each run.
//   A code below 32 or above 127 becomes '%', its decimal digits and '%';
//   a '%' becomes "%%"; every other code passes through as one character.
//   The first character of a run reaches out_ through the registered code,
//   then the output register. Throughput: one character per cycle on out_
//   while the receiver takes them; pass-through codes stream at one per cycle
//   likewise. For a longer run in_tready stays low until the last character
//   moves into the output register, the one output register that emits one
//   character of the run each cycle.
//   Reset (rst_n low, synchronous) drops any held code and output; no
//   clearing pass follows. When the receiver stalls, the output register
//   holds its character and any held code waits; in_tready is low while a
//   code is held, until the output register can move again.
module ascii_safe_escape_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ase_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] char_code
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ase_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [6:0] out_char, [7] zero fill
  output logic                             out_tlast
);
  import ase_pkg::*;

  logic     code_v_r, code_v_nxt;
  code_t    code_r, code_nxt;
  idx_t     idx_r, idx_nxt;
  logic     out_v_r, out_v_nxt;
  char_t    out_char_r;
  logic     out_last_r;
  ase_sym_t sym;
  logic     out_free;
  logic     adv;
  logic     in_acc;

  ase_run_sel u_run_sel (
    .code (code_r),
    .idx  (idx_r),
    .sym  (sym)
  );

  assign out_free  = !out_v_r || out_tready;
  assign adv       = code_v_r && out_free;
  assign in_tready = !code_v_r || (adv && sym.last);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    code_v_nxt = code_v_r;
    code_nxt   = code_r;
    idx_nxt    = idx_r;
    if (adv) begin
      if (sym.last) begin
        code_v_nxt = 1'b0;
        idx_nxt    = '0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (in_acc) begin
      code_v_nxt = 1'b1;
      code_nxt   = in_tdata;
      idx_nxt    = '0;
    end
    out_v_nxt = out_free ? code_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_v_r <= 1'b0;
      idx_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      code_v_r <= code_v_nxt;
      idx_r    <= idx_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (adv) begin
      out_char_r <= sym.ch;
      out_last_r <= sym.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

@@ src/ase_checker.sv @@
// Port-level checker of the escape encoder, bound to the top level.
// Depends on ase_pkg and ascii_safe_escape_encoder_assert.svh.
`include "ascii_safe_escape_encoder_assert.svh"

module ase_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ase_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] char_code
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ase_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [6:0] out_char, [7] zero fill
  input logic                             out_tlast
);
  import ase_pkg::*;

  logic in_seen;
  assign in_seen = in_tvalid && in_tready;

  // Reset empties the output register.
  `ASE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

  // Every emitted character is 7-bit ASCII with a code of 32 or above.
  `ASE_ASSERT(a_printable, out_tvalid |-> (!out_tdata[7] && out_tdata[6:5] != 2'b00))

  // A stalled transaction holds its character and end mark.
  `ASE_ASSERT(a_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))

  // A stalled output with a run still pending blocks new input.
  `ASE_ASSERT(a_stall_blocks, (out_tvalid && !out_tready && !out_tlast) |-> !in_seen)

endmodule

bind ascii_safe_escape_encoder ase_checker u_ase_checker (.*);

@@ verif/ascii_safe_escape_encoder_tb.sv @@
// Self-checking testbench for the ASCII-safe escape encoder: directed and random codes,
// random idling on both stream channels and one long output hold-off.
// Depends on ase_pkg and the ascii_safe_escape_encoder top level.
`timescale 1ns / 100ps

module ascii_safe_escape_encoder_tb;
  import ase_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [7:0] char_code
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [6:0] out_char, [7] zero fill
  logic                   out_tlast;

  ase_sym_t pending_chars[$];
  int       send_idle_pct  = 0;
  int       recv_idle_pct  = 0;
  logic     hold_off_go    = 1'b0;
  int       hold_off_cnt   = 0;
  int       cycle_count    = 0;
  int       mismatch_count = 0;
  int       codes_sent     = 0;
  int       chars_checked  = 0;
  int       escaped_sent   = 0;

  ascii_safe_escape_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ascii_safe_escape_encoder: mismatch");
      $finish;
    end
  end

  // Expected characters of one code's run, appended in emission order.
  function automatic void push_escape_run(input code_t code);
    if (code < LOW_LIMIT || code > HIGH_LIMIT) begin
      pending_chars.push_back(ase_sym_t'{PCT_CHAR, 1'b0});
      if (code >= 100)
        pending_chars.push_back(ase_sym_t'{DIGIT_ZERO + char_t'(code / 100), 1'b0});
      if (code >= 10)
        pending_chars.push_back(ase_sym_t'{DIGIT_ZERO + char_t'((code / 10) % 10), 1'b0});
      pending_chars.push_back(ase_sym_t'{DIGIT_ZERO + char_t'(code % 10), 1'b0});
      pending_chars.push_back(ase_sym_t'{PCT_CHAR, 1'b1});
    end else if (code == PCT_CODE) begin
      pending_chars.push_back(ase_sym_t'{PCT_CHAR, 1'b0});
      pending_chars.push_back(ase_sym_t'{PCT_CHAR, 1'b1});
    end else begin
      pending_chars.push_back(ase_sym_t'{char_t'(code), 1'b1});
    end
  endfunction

  // Half codes that get escaped, plenty of plain ones and a share of percent signs.
  function automatic code_t random_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25)      return code_t'($urandom_range(31));
    else if (pick < 50) return code_t'($urandom_range(255, 128));
    else if (pick < 62) return PCT_CODE;
    else if (pick < 66) return HIGH_LIMIT;
    else                return code_t'($urandom_range(126, 32));
  endfunction

  task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("error: %s: expected %0d, got %0d (cycle %0d)",
               what, exp_v, act_v, cycle_count);
  endtask

  // Offers one code and returns at the edge where the transaction completes.
  task automatic send_code(input code_t code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    push_escape_run(code);
    codes_sent++;
    if (code < LOW_LIMIT || code > HIGH_LIMIT) escaped_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    int unsigned codes[] = '{0, 1, 9, 10, 31, 32, 36, 37, 38, 65, 99, 100, 126, 127,
                             128, 8'h55, 8'hAA, 199, 200, 254, 255};
    send_idle_pct = 31;
    recv_idle_pct = 88;
    foreach (codes[i]) send_code(code_t'(codes[i]));
    drain();
  endtask

  task automatic test_random_slow_receiver(input int count);
    send_idle_pct = 31;
    recv_idle_pct = 88;
    repeat (count) send_code(random_code());
    drain();
  endtask

  task automatic test_random_slow_sender(input int count);
    send_idle_pct = 88;
    recv_idle_pct = 31;
    repeat (count) send_code(random_code());
    drain();
  endtask

  task automatic test_back_to_back(input int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (count) send_code(random_code());
    drain();
  endtask

  // The receiver stops for a long stretch while codes keep coming, so the input stalls.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_go <= 1'b1;
    repeat (20) send_code(random_code());
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_off_go && hold_off_cnt < HOLD_OFF_CYCLES) begin
      out_tready   <= 1'b0;
      hold_off_cnt <= hold_off_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_output
    ase_sym_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch("character with nothing pending", -1, int'(out_tdata[CHAR_W-1:0]));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_tdata[CHAR_W-1:0] !== want.ch)
          flag_mismatch("out_char", int'(want.ch), int'(out_tdata[CHAR_W-1:0]));
        if (out_tlast !== want.last)
          flag_mismatch("last", int'(want.last), int'(out_tlast));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_slow_receiver(40);
    test_random_slow_sender(40);
    test_back_to_back(40);
    test_output_hold_off();

    $display("Sent %0d codes (%0d escaped), checked %0d output characters,",
             codes_sent, escaped_sent, chars_checked);
    $display("under both idling mixes, back-to-back traffic and a long output stall.");
    if (mismatch_count == 0) begin
      $display("ascii_safe_escape_encoder: match");
    end else begin
      $display("ascii_safe_escape_encoder: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ase_pkg.sv
src/ase_run_sel.sv
src/ascii_safe_escape_encoder.sv
src/ase_checker.sv
verif/ascii_safe_escape_encoder_tb.sv
